// File: sv/fdmg_pkg.sv
// Package of shared types, constants and functions for the frame difference motion gate.
`default_nettype none

package fdmg_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned COUNT_W     = 23;
  localparam int unsigned PAD_W       = 11;
  localparam int unsigned DIM_CFG_W   = 12;
  localparam int unsigned COORD_OUT_W = 11;
  localparam int unsigned SIDE_OUT_W  = 12;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 23;
  localparam int unsigned DIM_CFG_MAX = (1 << DIM_CFG_W) - 1;

  localparam logic [PIX_W-1:0] THR_CAP = 8'd254;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_DIFF_LIMIT   = 3'd2,
    REG_MIN_CHANGES  = 3'd3,
    REG_ROI_PAD      = 3'd4
  } fdmg_reg_e;

  typedef struct packed {
    logic [DIM_CFG_W-1:0] frame_width;
    logic [DIM_CFG_W-1:0] frame_height;
    logic [PIX_W-1:0]     diff_limit;
    logic [COUNT_W-1:0]   min_changes;
    logic [PAD_W-1:0]     roi_pad;
  } fdmg_cfg_t;

  localparam fdmg_cfg_t CFG_RESET = '{
    frame_width:  12'd320,
    frame_height: 12'd240,
    diff_limit:   8'd16,
    min_changes:  23'd1,
    roi_pad:      11'd0
  };

  typedef struct packed {
    logic [PIX_W-1:0] curr_pixel;
    logic [PIX_W-1:0] prev_pixel;
  } fdmg_pix_t;

  typedef struct packed {
    logic                   gate_on;
    logic [COUNT_W-1:0]     changed_count;
    logic [COORD_OUT_W-1:0] roi_x;
    logic [COORD_OUT_W-1:0] roi_y;
    logic [SIDE_OUT_W-1:0]  roi_side;
  } fdmg_result_t;

  // Bits needed for a column or row position within the largest usable dimension.
  function automatic int unsigned pos_w(input int unsigned max_dim);
    int unsigned m;
    begin
      m = (max_dim < DIM_CFG_MAX) ? max_dim : DIM_CFG_MAX;
      return (m > 1) ? $clog2(m) : 1;
    end
  endfunction

  // A zero dimension acts as one; a dimension above the limit saturates.
  function automatic logic [DIM_CFG_W-1:0] dim_clamp(input logic [DIM_CFG_W-1:0] v,
                                                     input logic [DIM_CFG_W-1:0] maxv);
    logic [DIM_CFG_W-1:0] r;
    begin
      if (v == '0) begin
        r = DIM_CFG_W'(1);
      end else if (v > maxv) begin
        r = maxv;
      end else begin
        r = v;
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/fdmg_stream_if.sv
// Valid/ready stream interface carrying one item of a packed payload type.
`default_nettype none

interface fdmg_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// File: sv/frame_difference_motion_gate.sv
// Top level of the frame difference motion gate: configuration, input register and pipeline.
`default_nettype none

// Accepts one pair of current and previous pixels per clock in raster order while
// the pipeline is not stalled, and returns one result item per frame once the last
// pixel of the frame is taken: the item passes through the input register, change
// accumulator, region stage and result register in turn before it moves to the output
// register. A result waiting in the output register does not hold the pixel
// side; the pipeline stalls only when a second result reaches the result
// register before the first has been taken. Frame size, threshold, open count and
// padding are to be written through the register port between frames, a rule for the user
// that the block does not enforce. One-pixel frames give one result per clock unless stalled.
module frame_difference_motion_gate
  import fdmg_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  fdmg_stream_if.sink                pix_if,
  fdmg_stream_if.source              res_if
);

  localparam int unsigned CW = pos_w(MAX_WIDTH);
  localparam int unsigned RW = pos_w(MAX_HEIGHT);

  fdmg_cfg_t          cfg_q;
  logic               adv;
  logic               out_free;
  logic               pix_valid_q;
  fdmg_pix_t          pix_q;

  logic               fin_valid;
  logic [COUNT_W-1:0] fin_count;
  logic [CW-1:0]      fin_left, fin_right;
  logic [RW-1:0]      fin_top, fin_bottom;

  logic               res_valid;
  fdmg_result_t       res;

  logic               out_valid_q;
  fdmg_result_t       out_q;

  assign out_free     = !out_valid_q || res_if.ready;
  assign adv          = !res_valid || out_free;
  assign pix_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[DIM_CFG_W-1:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[DIM_CFG_W-1:0];
        REG_DIFF_LIMIT:   cfg_q.diff_limit   <= cfg_data_i[PIX_W-1:0];
        REG_MIN_CHANGES:  cfg_q.min_changes  <= cfg_data_i[COUNT_W-1:0];
        REG_ROI_PAD:      cfg_q.roi_pad      <= cfg_data_i[PAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else if (adv) begin
      pix_valid_q <= pix_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && pix_if.valid) begin
      pix_q <= pix_if.data;
    end
  end

  fdmg_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .pix_valid_i  (pix_valid_q),
    .pix_i        (pix_q),
    .cfg_i        (cfg_q),
    .fin_valid_o  (fin_valid),
    .fin_count_o  (fin_count),
    .fin_left_o   (fin_left),
    .fin_right_o  (fin_right),
    .fin_top_o    (fin_top),
    .fin_bottom_o (fin_bottom)
  );

  fdmg_roi #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_roi (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .fin_valid_i  (fin_valid),
    .fin_count_i  (fin_count),
    .fin_left_i   (fin_left),
    .fin_right_i  (fin_right),
    .fin_top_i    (fin_top),
    .fin_bottom_i (fin_bottom),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign res_if.valid = out_valid_q;
  assign res_if.data  = out_q;

endmodule

`default_nettype wire

// File: sv/fdmg_accum.sv
// Per-pixel change detection, raster position tracking and motion box accumulation.
`default_nettype none

module fdmg_accum
  import fdmg_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adv_i,
  input  wire logic                      pix_valid_i,
  input  fdmg_pix_t                      pix_i,
  input  fdmg_cfg_t                      cfg_i,
  output logic                           fin_valid_o,
  output logic [COUNT_W-1:0]             fin_count_o,
  output logic [pos_w(MAX_WIDTH)-1:0]    fin_left_o,
  output logic [pos_w(MAX_WIDTH)-1:0]    fin_right_o,
  output logic [pos_w(MAX_HEIGHT)-1:0]   fin_top_o,
  output logic [pos_w(MAX_HEIGHT)-1:0]   fin_bottom_o
);

  localparam int unsigned MW  = (MAX_WIDTH < DIM_CFG_MAX) ? MAX_WIDTH : DIM_CFG_MAX;
  localparam int unsigned MH  = (MAX_HEIGHT < DIM_CFG_MAX) ? MAX_HEIGHT : DIM_CFG_MAX;
  localparam int unsigned CW  = pos_w(MAX_WIDTH);
  localparam int unsigned RW  = pos_w(MAX_HEIGHT);
  localparam int unsigned WDW = $clog2(MW + 1);
  localparam int unsigned HDW = $clog2(MH + 1);

  logic [WDW-1:0]     w_eff;
  logic [HDW-1:0]     h_eff;
  logic [CW-1:0]      last_col;
  logic [RW-1:0]      last_row;
  logic [PIX_W-1:0]   thr;
  logic [PIX_W-1:0]   diff;
  logic               changed;
  logic               end_col;
  logic               frame_end;

  logic [CW-1:0]      col_q, col_d;
  logic [RW-1:0]      row_q, row_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               any_q, any_d;
  logic [CW-1:0]      left_q, left_d, right_q, right_d;
  logic [RW-1:0]      top_q, top_d, bottom_q, bottom_d;

  logic               fin_valid_q;
  logic [COUNT_W-1:0] fin_count_q;
  logic [CW-1:0]      fin_left_q, fin_right_q;
  logic [RW-1:0]      fin_top_q, fin_bottom_q;

  assign w_eff    = WDW'(dim_clamp(cfg_i.frame_width, DIM_CFG_W'(MW)));
  assign h_eff    = HDW'(dim_clamp(cfg_i.frame_height, DIM_CFG_W'(MH)));
  assign last_col = CW'(w_eff - WDW'(1));
  assign last_row = RW'(h_eff - HDW'(1));
  assign thr      = (cfg_i.diff_limit > THR_CAP) ? THR_CAP : cfg_i.diff_limit;
  assign diff     = (pix_i.curr_pixel > pix_i.prev_pixel) ?
                    (pix_i.curr_pixel - pix_i.prev_pixel) :
                    (pix_i.prev_pixel - pix_i.curr_pixel);
  assign changed   = diff > thr;
  assign end_col   = col_q >= last_col;
  assign frame_end = end_col && (row_q >= last_row);

  always_comb begin
    count_d  = count_q;
    any_d    = any_q;
    left_d   = left_q;
    right_d  = right_q;
    top_d    = top_q;
    bottom_d = bottom_q;
    if (changed) begin
      if (count_q != '1) begin
        count_d = count_q + COUNT_W'(1);
      end
      any_d = 1'b1;
      if (!any_q) begin
        left_d   = col_q;
        right_d  = col_q;
        top_d    = row_q;
        bottom_d = row_q;
      end else begin
        if (col_q < left_q) begin
          left_d = col_q;
        end
        if (col_q > right_q) begin
          right_d = col_q;
        end
        if (row_q < top_q) begin
          top_d = row_q;
        end
        if (row_q > bottom_q) begin
          bottom_d = row_q;
        end
      end
    end
    col_d = end_col ? '0 : (col_q + CW'(1));
    row_d = end_col ? (row_q + RW'(1)) : row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      count_q     <= '0;
      any_q       <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      top_q       <= '0;
      bottom_q    <= '0;
      fin_valid_q <= 1'b0;
    end else if (adv_i) begin
      fin_valid_q <= pix_valid_i && frame_end;
      if (pix_valid_i) begin
        if (frame_end) begin
          col_q    <= '0;
          row_q    <= '0;
          count_q  <= '0;
          any_q    <= 1'b0;
          left_q   <= '0;
          right_q  <= '0;
          top_q    <= '0;
          bottom_q <= '0;
        end else begin
          col_q    <= col_d;
          row_q    <= row_d;
          count_q  <= count_d;
          any_q    <= any_d;
          left_q   <= left_d;
          right_q  <= right_d;
          top_q    <= top_d;
          bottom_q <= bottom_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && pix_valid_i && frame_end) begin
      fin_count_q  <= count_d;
      fin_left_q   <= left_d;
      fin_right_q  <= right_d;
      fin_top_q    <= top_d;
      fin_bottom_q <= bottom_d;
    end
  end

  assign fin_valid_o  = fin_valid_q;
  assign fin_count_o  = fin_count_q;
  assign fin_left_o   = fin_left_q;
  assign fin_right_o  = fin_right_q;
  assign fin_top_o    = fin_top_q;
  assign fin_bottom_o = fin_bottom_q;

`ifndef SYNTHESIS
  a_any_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q == (count_q != '0))
    else $error("Change flag disagrees with the changed pixel count.");

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q |-> ((left_q <= right_q) && (top_q <= bottom_q)))
    else $error("Motion box edges are out of order.");
`endif

endmodule

`default_nettype wire

// File: sv/fdmg_roi.sv
// Gate decision and square region computation, with the result register.
`default_nettype none

module fdmg_roi
  import fdmg_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       adv_i,
  input  wire logic                       fin_valid_i,
  input  wire logic [COUNT_W-1:0]         fin_count_i,
  input  wire logic [pos_w(MAX_WIDTH)-1:0]  fin_left_i,
  input  wire logic [pos_w(MAX_WIDTH)-1:0]  fin_right_i,
  input  wire logic [pos_w(MAX_HEIGHT)-1:0] fin_top_i,
  input  wire logic [pos_w(MAX_HEIGHT)-1:0] fin_bottom_i,
  input  fdmg_cfg_t                       cfg_i,
  output logic                            res_valid_o,
  output fdmg_result_t                    res_o
);

  localparam int unsigned MW  = (MAX_WIDTH < DIM_CFG_MAX) ? MAX_WIDTH : DIM_CFG_MAX;
  localparam int unsigned MH  = (MAX_HEIGHT < DIM_CFG_MAX) ? MAX_HEIGHT : DIM_CFG_MAX;
  localparam int unsigned WDW = $clog2(MW + 1);
  localparam int unsigned HDW = $clog2(MH + 1);
  localparam int unsigned XW0 = (WDW > HDW) ? WDW : HDW;
  localparam int unsigned XW  = (XW0 > PAD_W + 1) ? XW0 : (PAD_W + 1);
  localparam int unsigned SW  = XW + 2;

  // Centres the square on the box midpoint and keeps it inside the frame.
  function automatic logic signed [SW-1:0] place(input logic signed [SW-1:0] mid,
                                                 input logic signed [SW-1:0] side,
                                                 input logic signed [SW-1:0] lim);
    logic signed [SW-1:0] s;
    begin
      s = mid - (side >>> 1);
      if (s < 0) begin
        s = '0;
      end else if ((s + side) > lim) begin
        s = lim - side;
      end
      return s;
    end
  endfunction

  logic [SW-1:0]        w_eff, h_eff;
  logic [SW-1:0]        pad2;
  logic [SW-1:0]        ext_x, ext_y;
  logic                 open_a;

  logic                 a_valid_q;
  logic                 a_open_q;
  logic [COUNT_W-1:0]   a_count_q;
  logic [SW-1:0]        a_side_q, a_side_d;
  logic [SW-1:0]        a_cap_q, a_cap_d;
  logic [SW-1:0]        a_midx_q, a_midx_d;
  logic [SW-1:0]        a_midy_q, a_midy_d;

  logic [SW-1:0]        side_b;
  logic signed [SW-1:0] sx, sy;

  logic                 res_valid_q;
  fdmg_result_t         res_q, res_d;

  assign w_eff  = SW'(dim_clamp(cfg_i.frame_width, DIM_CFG_W'(MW)));
  assign h_eff  = SW'(dim_clamp(cfg_i.frame_height, DIM_CFG_W'(MH)));
  assign pad2   = SW'({cfg_i.roi_pad, 1'b0});
  assign ext_x  = SW'(fin_right_i) - SW'(fin_left_i) + pad2;
  assign ext_y  = SW'(fin_bottom_i) - SW'(fin_top_i) + pad2;
  assign open_a = (fin_count_i != '0) && (fin_count_i >= cfg_i.min_changes);

  assign a_side_d = ((ext_x > ext_y) ? ext_x : ext_y) + SW'(1);
  assign a_cap_d  = (w_eff < h_eff) ? w_eff : h_eff;
  assign a_midx_d = (SW'(fin_left_i) + SW'(fin_right_i)) >> 1;
  assign a_midy_d = (SW'(fin_top_i) + SW'(fin_bottom_i)) >> 1;

  assign side_b = (a_side_q > a_cap_q) ? a_cap_q : a_side_q;
  assign sx     = place($signed(a_midx_q), $signed(side_b), $signed(w_eff));
  assign sy     = place($signed(a_midy_q), $signed(side_b), $signed(h_eff));

  always_comb begin
    res_d.gate_on       = a_open_q;
    res_d.changed_count = a_count_q;
    if (a_open_q) begin
      res_d.roi_x    = sx[COORD_OUT_W-1:0];
      res_d.roi_y    = sy[COORD_OUT_W-1:0];
      res_d.roi_side = side_b[SIDE_OUT_W-1:0];
    end else begin
      res_d.roi_x    = '0;
      res_d.roi_y    = '0;
      res_d.roi_side = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q   <= fin_valid_i;
      res_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && fin_valid_i) begin
      a_open_q  <= open_a;
      a_count_q <= fin_count_i;
      a_side_q  <= a_side_d;
      a_cap_q   <= a_cap_d;
      a_midx_q  <= a_midx_d;
      a_midy_q  <= a_midy_d;
    end
    if (adv_i && a_valid_q) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_closed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.gate_on) |->
      ((res_q.roi_x == '0) && (res_q.roi_y == '0) && (res_q.roi_side == '0)))
    else $error("Closed gate carries a non-zero region.");

  a_open_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.gate_on) |->
      ((res_q.changed_count != '0) && (res_q.roi_side != '0)))
    else $error("Open gate without changed pixels or with an empty region.");
`endif

endmodule

`default_nettype wire
